/* rtl/core/chirp_sine_generator_unit_defines.svh */
// ----------------------------------------------------------------------------
// Chirp sine generator assertion macros
// Shared concurrent assertion shorthands, clocked on clock, muted in reset.
// ----------------------------------------------------------------------------
`ifndef CHIRP_SINE_GENERATOR_UNIT_DEFINES_SVH
`define CHIRP_SINE_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/csg_pkg.sv */
// ----------------------------------------------------------------------------
// Chirp sine generator package
// Shared constants, register indexes, types and the sine table entry function.
// ----------------------------------------------------------------------------
package csg_pkg;

   // Default sizes of the generator.
   localparam int DEF_SINE_TABLE_DEPTH = 1024;
   localparam int DEF_SAMPLE_WIDTH     = 16;
   localparam int DEF_PHASE_WIDTH      = 32;

   // Fraction bits carried by the phase increment.
   localparam int INC_FRAC = 16;

   // Width of a stored sine table word: sign bit over a Q30 magnitude.
   localparam int ROM_WORD_W = 32;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_INCREMENT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_STEP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_RATIO       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_LENGTH    = 3'd5;

   // Sweep mode codes.
   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_LOG    = 1'b1;

   // Register reset values.
   localparam logic [31:0] RESET_LOG_RATIO    = 32'd1073741824;
   localparam logic [15:0] RESET_AMPLITUDE    = 16'd32767;
   localparam logic [31:0] RESET_SWEEP_LENGTH = 32'd48000;

   // Fixed-point constants of the sine series.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   // Configuration register file contents.
   typedef struct packed {
      logic               sweep_mode;
      logic [47:0]        start_increment;
      logic signed [47:0] linear_step;
      logic [31:0]        log_ratio;
      logic [15:0]        amplitude;
      logic [31:0]        sweep_length;
   } csg_cfg_type;

   // Control that travels with an item down the pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } csg_tag_type;

   // Sine of a Q32 angle in turns, as {negative, Q30 magnitude}. The angle is
   // folded to a quarter wave and a Taylor series to the 13th power is summed
   // with truncating arithmetic. Only used while building the table.
   function automatic logic [ROM_WORD_W-1:0] sine_entry(input logic [31:0] ang);
      longint unsigned r;
      longint unsigned th;
      longint unsigned th2;
      longint unsigned term;
      longint unsigned sum;
      r = {34'd0, ang[29:0]};
      if (ang[30]) begin
         r = ONE_Q30 - r;
      end
      th   = (r * HALF_PI_Q30) >> 30;
      th2  = (th * th) >> 30;
      term = th;
      sum  = th;
      term = ((term * th2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * th2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * th2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * th2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * th2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * th2) >> 30) / 64'd156;
      sum  = sum + term;
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return {ang[31], sum[ROM_WORD_W-2:0]};
   endfunction

endpackage

/* rtl/core/csg_sweep.sv */
// ----------------------------------------------------------------------------
// Chirp sweep state
// Holds phase, increment and sample count, applies restart, advances the
// sweep once per accepted request and registers the table index and flag.
// ----------------------------------------------------------------------------
`include "chirp_sine_generator_unit_defines.svh"

module csg_sweep #(
   parameter int SINE_TABLE_DEPTH = csg_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int PHASE_WIDTH      = csg_pkg::DEF_PHASE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  csg_pkg::csg_cfg_type             cfg,
   input  logic                             req_valid,
   input  logic                             req_restart,
   output logic                             up_ready,
   input  logic                             dn_ready,
   output csg_pkg::csg_tag_type             tag_ff,
   output logic [$clog2(SINE_TABLE_DEPTH)-1:0] idx_ff
);
   import csg_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int INC_W = PHASE_WIDTH + INC_FRAC;
   localparam logic [INC_W-1:0] IMAX = '1;
   localparam logic [65:0]      IMAX_EXT = 66'(IMAX);
   localparam logic [95:0]      LOG_ROUND = 96'(1) << 29;

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in, phase_eff;
   logic [INC_W-1:0]       inc_ff, inc_in, inc_eff, inc_start;
   logic [31:0]            count_ff, count_in, count_eff;
   csg_tag_type            tag_in;
   logic [IDX_W-1:0]       idx_in;
   logic                   acc;

   logic [31:0]            phase_q32;
   logic [48:0]            idx_prod;
   logic signed [65:0]     lin_sum;
   logic [INC_W-1:0]       lin_inc;
   logic [63:0]            inc_wide;
   logic [63:0]            log_hi, log_lo;
   logic [95:0]            log_sum;
   logic [65:0]            log_res;
   logic [INC_W-1:0]       log_inc;

   // The stage takes a new item when it is empty or its item moves on.
   assign up_ready = !tag_ff.valid || dn_ready;
   assign acc      = req_valid && up_ready;

   // A restart puts the sweep back to its start before this sample.
   assign inc_start = INC_W'(64'(cfg.start_increment));
   assign phase_eff = req_restart ? '0 : phase_ff;
   assign inc_eff   = req_restart ? inc_start : inc_ff;
   assign count_eff = req_restart ? '0 : count_ff;

   // Table index: top 32 phase bits scaled by the table depth.
   assign phase_q32 = 32'({phase_eff, 32'd0} >> PHASE_WIDTH);
   assign idx_prod  = 49'(phase_q32) * 49'(SINE_TABLE_DEPTH);
   assign idx_in    = idx_prod[32 +: IDX_W];

   assign tag_in.valid = req_valid;
   assign tag_in.last  = (count_eff == (cfg.sweep_length - 32'd1));

   // Phase advances by the integer part of the increment and wraps.
   assign phase_in = phase_eff + inc_eff[INC_W-1:INC_FRAC];
   assign count_in = count_eff + 32'd1;

   // Linear mode: signed step, clamped to zero and to the maximum.
   assign lin_sum = $signed({2'b00, 64'(inc_eff)}) + 66'(cfg.linear_step);
   always_comb begin
      priority if (lin_sum[65]) begin
         lin_inc = '0;
      end else if ($unsigned(lin_sum) > IMAX_EXT) begin
         lin_inc = IMAX;
      end else begin
         lin_inc = INC_W'(lin_sum);
      end
   end

   // Log mode: Q2.30 product in two 32-bit halves, rounded at bit 30.
   assign inc_wide = 64'(inc_eff);
   assign log_hi   = 64'(inc_wide[63:32]) * 64'(cfg.log_ratio);
   assign log_lo   = 64'(inc_wide[31:0]) * 64'(cfg.log_ratio);
   assign log_sum  = {log_hi, 32'd0} + 96'(log_lo) + LOG_ROUND;
   assign log_res  = log_sum[95:30];
   assign log_inc  = (log_res > IMAX_EXT) ? IMAX : INC_W'(log_res);

   assign inc_in = (cfg.sweep_mode == MODE_LOG) ? log_inc : lin_inc;

   // Sweep state moves only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         inc_ff   <= '0;
         count_ff <= '0;
      end else if (acc) begin
         phase_ff <= phase_in;
         inc_ff   <= inc_in;
         count_ff <= count_in;
      end
   end

   // Output stage toward the sine table.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (up_ready) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         idx_ff <= idx_in;
      end
   end

   `CSG_ASSERT_NEXT(a_restart_count, acc && req_restart, count_ff == 32'd1,
      "sample count not one after a restart")
   `CSG_ASSERT_NEXT(a_idle_hold, !acc, $stable(phase_ff) && $stable(count_ff),
      "sweep state moved without a request")
   `CSG_ASSERT_NEXT(a_log_zero, acc && !req_restart && cfg.sweep_mode == MODE_LOG
      && inc_ff == '0, inc_ff == '0, "zero increment moved in log mode")
   `CSG_ASSERT_SAME(a_stall_full, !up_ready, tag_ff.valid,
      "stage stalled while empty")

endmodule

/* rtl/core/csg_sine_rom.sv */
// ----------------------------------------------------------------------------
// Chirp sine table
// Full-wave sine table built at elaboration, read with a registered port.
// ----------------------------------------------------------------------------
module csg_sine_rom #(
   parameter int SINE_TABLE_DEPTH = csg_pkg::DEF_SINE_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  csg_pkg::csg_tag_type                up_tag,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] up_idx,
   output logic                                up_ready,
   input  logic                                dn_ready,
   output csg_pkg::csg_tag_type                tag_ff,
   output logic [csg_pkg::ROM_WORD_W-1:0]      data_ff
);
   import csg_pkg::*;

   typedef logic [ROM_WORD_W-1:0] rom_type [SINE_TABLE_DEPTH];

   // Entry i holds the sine of i / depth turns.
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] ang;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         ang    = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
         rom[i] = sine_entry(ang[31:0]);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   assign up_ready = !tag_ff.valid || dn_ready;

   // Tag of the item whose table word is being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (up_ready) begin
         tag_ff <= up_tag;
      end
   end

   // Registered table read.
   always_ff @(posedge clock) begin
      if (up_ready && up_tag.valid) begin
         data_ff <= SINE_ROM[up_idx];
      end
   end

endmodule

/* rtl/core/csg_shaper.sv */
// ----------------------------------------------------------------------------
// Chirp sample shaper
// Scales the table magnitude by the amplitude, rounds, saturates, applies
// the sign and holds the result for the response channel.
// ----------------------------------------------------------------------------
module csg_shaper #(
   parameter int SAMPLE_WIDTH = csg_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [15:0]                    amplitude,
   input  csg_pkg::csg_tag_type           up_tag,
   input  logic [csg_pkg::ROM_WORD_W-1:0] up_data,
   output logic                           up_ready,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic                           rsp_tlast,
   output logic [SAMPLE_WIDTH-1:0]        rsp_sample
);
   import csg_pkg::*;

   localparam int SHIFT = 46 - SAMPLE_WIDTH;
   localparam logic [47:0] ROUND = 48'(1) << (SHIFT - 1);
   localparam logic [47:0] LIMIT = (48'(1) << (SAMPLE_WIDTH - 1)) - 48'd1;

   csg_tag_type             prod_tag_ff;
   logic [46:0]             prod_ff;
   logic                    neg_ff;
   logic                    prod_ready;
   logic                    out_ready;
   logic [47:0]             rounded;
   logic [47:0]             mag_sat;
   logic [SAMPLE_WIDTH-1:0] sample_in;

   assign out_ready  = !rsp_tvalid || rsp_tready;
   assign prod_ready = !prod_tag_ff.valid || out_ready;
   assign up_ready   = prod_ready;

   // Product stage: magnitude times gain.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
      end else if (prod_ready) begin
         prod_tag_ff <= up_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && up_tag.valid) begin
         prod_ff <= 47'(up_data[ROM_WORD_W-2:0]) * 47'(amplitude);
         neg_ff  <= up_data[ROM_WORD_W-1];
      end
   end

   // Round half up, saturate the magnitude, then apply the sign.
   assign rounded   = (48'(prod_ff) + ROUND) >> SHIFT;
   assign mag_sat   = (rounded > LIMIT) ? LIMIT : rounded;
   assign sample_in = neg_ff ? SAMPLE_WIDTH'(48'd0 - mag_sat) : SAMPLE_WIDTH'(mag_sat);

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (out_ready) begin
         rsp_tvalid <= prod_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && prod_tag_ff.valid) begin
         rsp_sample <= sample_in;
         rsp_tlast  <= prod_tag_ff.last;
      end
   end

endmodule

/* rtl/core/chirp_sine_generator_unit.sv */
// A response passes the sweep, table read, product and response registers
// after its request is accepted. Throughput: one request per cycle unless
// the response channel stalls; the sweep loop has one increment adder or
// one split Q2.30 multiplier. Reset clears the pipeline and sweep state and
// loads the register defaults; requests are taken as soon as it is released.
// ----------------------------------------------------------------------------
// Chirp sine generator
// Phase-accumulator sine source with a linear or logarithmic frequency sweep,
// one sample per request, configured through a register write channel.
// ----------------------------------------------------------------------------
module chirp_sine_generator_unit #(
   parameter int SINE_TABLE_DEPTH = csg_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH     = csg_pkg::DEF_SAMPLE_WIDTH,
   parameter int PHASE_WIDTH      = csg_pkg::DEF_PHASE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [0] restart
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     rsp_tdata,   // [SAMPLE_WIDTH-1:0] sample
   output logic                                  rsp_tlast,   // last_of_sweep
   // Register write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [csg_pkg::CSR_DATA_W-1:0]        csr_data
);
   import csg_pkg::*;

   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   csg_cfg_type             cfg_ff, cfg_in;
   csg_tag_type             sweep_tag, rom_tag;
   logic [IDX_W-1:0]        sweep_idx;
   logic [ROM_WORD_W-1:0]   rom_data;
   logic                    rom_ready, shaper_ready;
   logic [SAMPLE_WIDTH-1:0] rsp_sample;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SWEEP_MODE:      cfg_in.sweep_mode      = csr_data[0];
            CSR_START_INCREMENT: cfg_in.start_increment = csr_data[47:0];
            CSR_LINEAR_STEP:     cfg_in.linear_step     = $signed(csr_data[47:0]);
            CSR_LOG_RATIO:       cfg_in.log_ratio       = csr_data[31:0];
            CSR_AMPLITUDE:       cfg_in.amplitude       = csr_data[15:0];
            CSR_SWEEP_LENGTH:    cfg_in.sweep_length    = csr_data[31:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_mode      <= MODE_LINEAR;
         cfg_ff.start_increment <= '0;
         cfg_ff.linear_step     <= '0;
         cfg_ff.log_ratio       <= RESET_LOG_RATIO;
         cfg_ff.amplitude       <= RESET_AMPLITUDE;
         cfg_ff.sweep_length    <= RESET_SWEEP_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sweep state and table index.
   csg_sweep #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_WIDTH      (PHASE_WIDTH)
   ) u_sweep (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_restart (req_tdata[0]),
      .up_ready    (req_tready),
      .dn_ready    (rom_ready),
      .tag_ff      (sweep_tag),
      .idx_ff      (sweep_idx)
   );

   // Sine table lookup.
   csg_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock    (clock),
      .reset    (reset),
      .up_tag   (sweep_tag),
      .up_idx   (sweep_idx),
      .up_ready (rom_ready),
      .dn_ready (shaper_ready),
      .tag_ff   (rom_tag),
      .data_ff  (rom_data)
   );

   // Gain, rounding and response register.
   csg_shaper #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_shaper (
      .clock      (clock),
      .reset      (reset),
      .amplitude  (cfg_ff.amplitude),
      .up_tag     (rom_tag),
      .up_data    (rom_data),
      .up_ready   (shaper_ready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_sample (rsp_sample)
   );

   assign rsp_tdata = TDATA_W'(rsp_sample);

endmodule
